// ===== rtl/core/lsm_pkg.sv =====
// lsm_pkg: shared sizes, codes, types and the case-fold function of the
// line substring matcher; no dependencies, imported by every rtl/core module
package lsm_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int LINE_MAX    = 8192;

  // field widths
  localparam int BYTE_W = 8;
  localparam int SLOT_W = 6;
  localparam int LEN_W  = 7;
  localparam int OFF_W  = 13;

  // derived sizes
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LIM_W = $clog2(PATTERN_MAX + 1);
  localparam int CNT_W = $clog2(LINE_MAX + 1);

  // apb port
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [BYTE_W-1:0] CASE_DELTA   = 8'h20;

  typedef enum logic {
    REQ_LINE = 1'b0,
    REQ_LOAD = 1'b1
  } req_type_t;

  typedef enum logic {
    REG_CASE_INS = 1'b0,
    REG_PAT_LEN  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             case_insensitive;
    logic [LEN_W-1:0] pattern_length;
  } cfg_t;

  typedef struct packed {
    logic [PATTERN_MAX-1:0] hit;
    logic [PATTERN_MAX-1:0] end_sel;
    logic [IDX_W-1:0]       end_idx;
    logic                   empty;
  } pat_info_t;

  typedef struct packed {
    logic             matched;
    logic [OFF_W-1:0] offset;
  } result_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                   input logic ci);
    logic [BYTE_W-1:0] r;
    r = c;
    if (ci && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/lsm_cfg_regs.sv =====
// lsm_cfg_regs: apb register file holding the case mode and pattern length
// depends on lsm_pkg
module lsm_cfg_regs import lsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic             case_ins_r;
  logic [LEN_W-1:0] pat_len_r;
  logic             wr_en;
  reg_idx_t         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  // byte address 4*i, low bits ignored
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_ins_r <= 1'b0;
      pat_len_r  <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_CASE_INS: case_ins_r <= pwdata[0];
        REG_PAT_LEN:  pat_len_r  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CASE_INS: prdata = APB_DW'(case_ins_r);
      REG_PAT_LEN:  prdata = APB_DW'(pat_len_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.case_insensitive = case_ins_r;
  assign cfg.pattern_length   = pat_len_r;

endmodule

// ===== rtl/core/lsm_pattern_bank.sv =====
// lsm_pattern_bank: pattern byte store with per-lane compare against the
// current line byte, and the one-hot lane that closes the effective pattern
// depends on lsm_pkg
module lsm_pattern_bank import lsm_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] slot,
  input  logic [BYTE_W-1:0] wdata,
  input  cfg_t              cfg,
  input  logic [BYTE_W-1:0] line_byte,
  output pat_info_t         info
);

  logic [BYTE_W-1:0]      store_r [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] nz_r;
  logic [IDX_W-1:0]       widx;
  logic                   wr_ok;
  logic [LIM_W-1:0]       lim;
  logic [BYTE_W-1:0]      c;
  logic [PATTERN_MAX-1:0] prefix;
  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX-1:0] end_sel;
  logic [IDX_W-1:0]       end_idx;

  assign widx  = IDX_W'(slot);
  assign wr_ok = we && (32'(slot) < PATTERN_MAX);

  // nz_r marks lanes holding a nonzero byte, written alongside the store
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      store_r[widx] <= wdata;
      nz_r[widx]    <= (wdata != '0);
    end
  end

  assign lim = (32'(cfg.pattern_length) > PATTERN_MAX) ? LIM_W'(PATTERN_MAX)
                                                       : LIM_W'(cfg.pattern_length);
  assign c   = fold_byte(line_byte, cfg.case_insensitive);

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_lane
    assign hit[k]    = nz_r[k] && (fold_byte(store_r[k], cfg.case_insensitive) == c);
    assign prefix[k] = &nz_r[k:0];
    // lane k ends the pattern when the next byte is zero or the length stops here
    if (k == PATTERN_MAX - 1) begin : g_last
      assign end_sel[k] = prefix[k] && (LIM_W'(k) < lim);
    end else begin : g_mid
      assign end_sel[k] = prefix[k] && (LIM_W'(k) < lim) &&
                          ((LIM_W'(k + 1) == lim) || !nz_r[k + 1]);
    end
  end

  always_comb begin
    end_idx = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (end_sel[k]) begin
        end_idx = end_idx | IDX_W'(k);
      end
    end
  end

  assign info.hit     = hit;
  assign info.end_sel = end_sel;
  assign info.end_idx = end_idx;
  assign info.empty   = (lim == '0) || !nz_r[0];

endmodule

// ===== rtl/core/lsm_match_core.sv =====
// lsm_match_core: shift-and partial match vector, line offset counter and
// first-match tracking; result formed at the end-of-line byte; depends on lsm_pkg
module lsm_match_core import lsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] line_byte,
  input  logic              eol,
  input  pat_info_t         info,
  output result_t           result
);

  logic [PATTERN_MAX-1:0] pmv_r, pmv_nxt, pmv_shift;
  logic [CNT_W-1:0]       off_r, off_nxt;
  logic                   found_r, found_nxt;
  logic [OFF_W-1:0]       start_r, start_nxt;
  logic                   zseen_r, zseen_nxt;
  logic                   search;
  logic                   new_hit;
  logic [OFF_W-1:0]       start_calc;

  assign zseen_nxt  = zseen_r || (line_byte == '0);
  assign search     = !zseen_nxt && (32'(off_r) < LINE_MAX);
  assign pmv_shift  = {pmv_r[PATTERN_MAX-2:0], 1'b1} & info.hit;
  assign new_hit    = search && !info.empty && !found_r && |(info.end_sel & pmv_shift);
  assign start_calc = OFF_W'(off_r) - OFF_W'(info.end_idx);
  assign pmv_nxt    = search ? pmv_shift : pmv_r;
  assign off_nxt    = search ? off_r + CNT_W'(1) : off_r;
  assign found_nxt  = found_r || new_hit;
  assign start_nxt  = new_hit ? start_calc : start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmv_r   <= '0;
      off_r   <= '0;
      found_r <= 1'b0;
      start_r <= '0;
      zseen_r <= 1'b0;
    end else if (step) begin
      if (eol) begin
        pmv_r   <= '0;
        off_r   <= '0;
        found_r <= 1'b0;
        start_r <= '0;
        zseen_r <= 1'b0;
      end else begin
        pmv_r   <= pmv_nxt;
        off_r   <= off_nxt;
        found_r <= found_nxt;
        start_r <= start_nxt;
        zseen_r <= zseen_nxt;
      end
    end
  end

  // empty pattern always matches at offset zero
  assign result.matched = info.empty || found_nxt;
  assign result.offset  = (!info.empty && found_nxt) ? start_nxt : '0;

endmodule

// ===== rtl/core/line_substring_matcher_unit.sv =====
// line_substring_matcher_unit: top level with input register, result register
// and handshakes; depends on lsm_pkg, lsm_cfg_regs, lsm_pattern_bank, lsm_match_core
//
// Searches each line of a byte stream for one stored pattern of up to 64 bytes,
// exactly or ignoring ASCII letter case. Pattern bytes are loaded as items with
// req_type 1; line bytes (req_type 0) are taken one per cycle, and the byte
// flagged end_of_line yields one result: matched and the start offset of the
// first occurrence. The block sustains one item per clock; a result appears on
// the out_ port once the end-of-line item in the input register passes the
// combinational match update into the result register; an end-of-line byte
// waits in the input register while an earlier result is still held. A zero
// byte stops the search for the rest of the line, bytes past offset 8191 are
// not searched, and an empty pattern matches at offset 0. Pattern loads and
// register writes apply from the next line byte.
// Registers: case_insensitive at address 0, pattern_length at address 4.
module line_substring_matcher_unit import lsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [SLOT_W-1:0] in_pattern_slot,
  input  logic              in_end_of_line,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_matched,
  output logic [OFF_W-1:0]  out_match_offset,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic              s1_valid_r;
  req_type_t         s1_req_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_eol_r;
  logic              s1_line;
  logic              s1_emits;
  logic              s1_fire;
  logic              out_free;
  logic              in_xfer;
  logic              out_valid_r;
  result_t           res_r;
  cfg_t              cfg;
  pat_info_t         info;
  result_t           result;

  assign s1_line  = s1_valid_r && (s1_req_r == REQ_LINE);
  assign s1_emits = s1_line && s1_eol_r;
  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && (!s1_emits || out_free);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req_r  <= req_type_t'(in_req_type);
      s1_byte_r <= in_data_byte;
      s1_slot_r <= in_pattern_slot;
      s1_eol_r  <= in_end_of_line;
    end
  end

  lsm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsm_pattern_bank u_bank (
    .clk       (clk),
    .we        (s1_fire && (s1_req_r == REQ_LOAD)),
    .slot      (s1_slot_r),
    .wdata     (s1_byte_r),
    .cfg       (cfg),
    .line_byte (s1_byte_r),
    .info      (info)
  );

  lsm_match_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_fire && s1_line),
    .line_byte (s1_byte_r),
    .eol       (s1_eol_r),
    .info      (info),
    .result    (result)
  );

  // result register, refilled as soon as the waiting result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_emits) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emits) begin
      res_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_matched      = res_r.matched;
  assign out_match_offset = res_r.offset;

endmodule

// ===== rtl/core/lsm_checker.sv =====
// lsm_checker: port-level assertions for line_substring_matcher_unit, bound
// to the top level below; depends on lsm_pkg
module lsm_checker import lsm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_matched,
  input logic [OFF_W-1:0]  out_match_offset,
  input logic              pready
);

  // a held result keeps its payload until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_matched) &&
                                $stable(out_match_offset))
    else $error("result changed while stalled");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_match_offset == '0)
    else $error("offset nonzero without a match");

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("handshake not clean after reset");

  // with the result side free, input is never held off
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(!out_valid) && $past(rst_n) |-> in_ready)
    else $error("input stalled with no result pending");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind line_substring_matcher_unit lsm_checker u_lsm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_matched      (out_matched),
  .out_match_offset (out_match_offset),
  .pready           (pready)
);
